[rtl/assert_macros.svh]
// Assertion macros used by the checker module of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge except while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: assertion failed");

// Property checked on every rising edge, reset included.
`define ASSERT_CLK(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("%m: assertion failed");

`endif

[rtl/mrrm_pkg.sv]
// Shared types, codes and the CRC-16/Modbus byte update for the read register master.
package mrrm_pkg;

   // Request operations carried in req_tuser.
   localparam logic [1:0] OP_START   = 2'd0;
   localparam logic [1:0] OP_RX_BYTE = 2'd1;
   localparam logic [1:0] OP_TIMEOUT = 2'd2;

   // Result kinds carried in rsp_tuser.
   localparam logic KIND_REQUEST = 1'b0;
   localparam logic KIND_RESULT  = 1'b1;

   // Result status codes.
   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_TIMEOUT   = 3'd1;
   localparam logic [2:0] STATUS_CRC_ERROR = 3'd2;
   localparam logic [2:0] STATUS_WRONG_ID  = 3'd3;
   localparam logic [2:0] STATUS_EXCEPTION = 3'd4;

   // Configuration register indexes.
   localparam int unsigned     CSR_INDEX_W       = 2;
   localparam logic [1:0]      CSR_SLAVE_ADDRESS = 2'd0;
   localparam logic [1:0]      CSR_MAX_VALUE     = 2'd1;

   // Protocol constants.
   localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
   localparam logic [7:0]  EXCEPTION_BIT     = 8'h80;
   localparam logic [15:0] READ_COUNT        = 16'h0001;
   localparam logic [15:0] CRC_INIT          = 16'hFFFF;
   localparam logic [15:0] CRC_POLY          = 16'hA001;
   localparam logic [2:0]  REPLY_LAST_INDEX  = 3'd6;
   localparam logic [2:0]  FRAME_LAST_INDEX  = 3'd7;

   // Byte from the request frame sequencer.
   typedef struct packed {
      logic       busy;
      logic [7:0] tx_byte;
      logic       last;
   } seq_out_type;

   // Completed read from the reply collector.
   typedef struct packed {
      logic        valid;
      logic [2:0]  status;
      logic [15:0] read_value;
   } reply_out_type;

   // One byte of CRC-16/Modbus, reflected, eight shift steps.
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc_val,
                                              input logic [7:0]  data_byte);
      logic [15:0] c;
      c = crc_val ^ {8'h00, data_byte};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

[rtl/mrrm_request.sv]
// Request frame sequencer: sends the eight request bytes with a running CRC, one a cycle when advanced.
module mrrm_request (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [15:0]          reg_address,
   input  logic [7:0]           slave_address,
   input  logic                 advance,
   output mrrm_pkg::seq_out_type seq_out
);
   import mrrm_pkg::*;

   logic        busy_ff, busy_in;
   logic [2:0]  count_ff, count_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] reg_ff, reg_in;
   logic [7:0]  cur_byte;

   always_comb begin
      unique case (count_ff)
         3'd0:    cur_byte = slave_address;
         3'd1:    cur_byte = FUNC_READ_HOLDING;
         3'd2:    cur_byte = reg_ff[15:8];
         3'd3:    cur_byte = reg_ff[7:0];
         3'd4:    cur_byte = READ_COUNT[15:8];
         3'd5:    cur_byte = READ_COUNT[7:0];
         3'd6:    cur_byte = crc_ff[7:0];
         3'd7:    cur_byte = crc_ff[15:8];
         default: cur_byte = 8'h00;
      endcase
   end

   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      crc_in   = crc_ff;
      reg_in   = reg_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = 3'd0;
         crc_in   = CRC_INIT;
         reg_in   = reg_address;
      end else if (busy_ff && advance) begin
         count_in = count_ff + 3'd1;
         // The two CRC bytes themselves do not enter the CRC.
         if (count_ff < REPLY_LAST_INDEX) begin
            crc_in = crc16_byte(crc_ff, cur_byte);
         end
         if (count_ff == FRAME_LAST_INDEX) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= 3'd0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
      crc_ff <= crc_in;
      reg_ff <= reg_in;
   end

   assign seq_out.busy    = busy_ff;
   assign seq_out.tx_byte = cur_byte;
   assign seq_out.last    = (count_ff == FRAME_LAST_INDEX);

endmodule

[rtl/mrrm_reply.sv]
// Reply collector: gathers the seven response bytes, checks them and forms the read result, or a timeout result.
module mrrm_reply (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   rx_valid,
   input  logic                   timeout,
   input  logic [7:0]             rx_byte,
   input  logic [7:0]             slave_address,
   input  logic [15:0]            max_value,
   output mrrm_pkg::reply_out_type reply_out
);
   import mrrm_pkg::*;

   logic        awaiting_ff, awaiting_in;
   logic [2:0]  count_ff, count_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  addr_ff, addr_in;
   logic [7:0]  func_ff, func_in;
   logic [7:0]  data_hi_ff, data_hi_in;
   logic [7:0]  data_lo_ff, data_lo_in;
   logic [15:0] crc_next;
   logic [15:0] data_word;

   assign crc_next  = crc16_byte(crc_ff, rx_byte);
   assign data_word = {data_hi_ff, data_lo_ff};

   always_comb begin
      awaiting_in          = awaiting_ff;
      count_in             = count_ff;
      crc_in               = crc_ff;
      addr_in              = addr_ff;
      func_in              = func_ff;
      data_hi_in           = data_hi_ff;
      data_lo_in           = data_lo_ff;
      reply_out.valid      = 1'b0;
      reply_out.status     = STATUS_OK;
      reply_out.read_value = 16'h0000;

      if (start) begin
         // A new request drops whatever part of a reply has come in.
         awaiting_in = 1'b1;
         count_in    = 3'd0;
         crc_in      = CRC_INIT;
      end else if (awaiting_ff && timeout) begin
         reply_out.valid  = 1'b1;
         reply_out.status = STATUS_TIMEOUT;
         awaiting_in      = 1'b0;
         count_in         = 3'd0;
         crc_in           = CRC_INIT;
      end else if (awaiting_ff && rx_valid) begin
         case (count_ff)
            3'd0:    addr_in    = rx_byte;
            3'd1:    func_in    = rx_byte;
            3'd3:    data_hi_in = rx_byte;
            3'd4:    data_lo_in = rx_byte;
            default: ;
         endcase
         crc_in   = crc_next;
         count_in = count_ff + 3'd1;
         if (count_ff == REPLY_LAST_INDEX) begin
            reply_out.valid = 1'b1;
            if (crc_next != 16'h0000) begin
               reply_out.status = STATUS_CRC_ERROR;
            end else if (addr_ff != slave_address) begin
               reply_out.status = STATUS_WRONG_ID;
            end else if ((func_ff & EXCEPTION_BIT) != 8'h00) begin
               reply_out.status = STATUS_EXCEPTION;
            end else begin
               reply_out.status     = STATUS_OK;
               reply_out.read_value = (data_word > max_value) ? max_value : data_word;
            end
            awaiting_in = 1'b0;
            count_in    = 3'd0;
            crc_in      = CRC_INIT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_ff <= 1'b0;
         count_ff    <= 3'd0;
         crc_ff      <= CRC_INIT;
      end else begin
         awaiting_ff <= awaiting_in;
         count_ff    <= count_in;
         crc_ff      <= crc_in;
      end
      addr_ff    <= addr_in;
      func_ff    <= func_in;
      data_hi_ff <= data_hi_in;
      data_lo_ff <= data_lo_in;
   end

endmodule

[rtl/modbus_read_register_master.sv]
// Top level of the Modbus RTU read holding register master.
//
//   Channel  Direction  Handshake              Carries
//   req_     in         req_tvalid/req_tready  start, received byte or timeout request
//   rsp_     out        rsp_tvalid/rsp_tready  request frame bytes and read results
//   csr_     in         csr_valid/csr_ready    slave address and maximum value writes
//
// A received-byte or timeout request is taken and its result, if any, is registered in
// the output stage at the same edge. A start request is taken and the request sequencer
// then sends its eight frame bytes one per cycle while the output register can take them,
// so the next request is taken once the eighth byte has entered the output register.
// Reset is synchronous and active high; it empties the output stage, stops the
// sequencer, drops any pending read and restores the configuration to its reset values.
// While rsp_tready is low a waiting result holds in the output register and req_tready falls.
module modbus_read_register_master (
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,    // [1:0] operation
   input  logic [23:0] req_tdata,    // [15:0] reg_address, [23:16] rx_byte
   // Result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic        rsp_tuser,    // [0] kind
   output logic        rsp_tlast,    // last byte of the request frame
   output logic [31:0] rsp_tdata,    // [7:0] tx_byte, [10:8] status, [26:11] read_value
   // Configuration channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [mrrm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0] csr_data
);
   import mrrm_pkg::*;

   logic          out_free;
   logic          req_accept;
   logic          op_start;
   logic          op_rx_byte;
   logic          op_timeout;
   seq_out_type   seq_out;
   reply_out_type reply_out;

   logic [7:0]  slave_address_ff, slave_address_in;
   logic [15:0] max_value_ff, max_value_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_kind_ff, rsp_kind_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic        rsp_last_ff, rsp_last_in;
   logic [2:0]  rsp_status_ff, rsp_status_in;
   logic [15:0] rsp_value_ff, rsp_value_in;

   // The output register can take a new result when it is empty or being emptied.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !seq_out.busy && out_free;
   assign req_accept = req_tvalid && req_tready;
   assign op_start   = req_accept && (req_tuser == OP_START);
   assign op_rx_byte = req_accept && (req_tuser == OP_RX_BYTE);
   assign op_timeout = req_accept && (req_tuser == OP_TIMEOUT);

   // Configuration registers; writes are always accepted.
   assign csr_ready = 1'b1;

   always_comb begin
      slave_address_in = slave_address_ff;
      max_value_in     = max_value_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SLAVE_ADDRESS: slave_address_in = csr_data[7:0];
            CSR_MAX_VALUE:     max_value_in     = csr_data;
            default:           ;
         endcase
      end
   end

   mrrm_request u_request (
      .clock         (clock),
      .reset         (reset),
      .start         (op_start),
      .reg_address   (req_tdata[15:0]),
      .slave_address (slave_address_ff),
      .advance       (out_free),
      .seq_out       (seq_out)
   );

   mrrm_reply u_reply (
      .clock         (clock),
      .reset         (reset),
      .start         (op_start),
      .rx_valid      (op_rx_byte),
      .timeout       (op_timeout),
      .rx_byte       (req_tdata[23:16]),
      .slave_address (slave_address_ff),
      .max_value     (max_value_ff),
      .reply_out     (reply_out)
   );

   // Output register: a frame byte while the sequencer runs, otherwise a read result.
   // Requests are held off while the sequencer runs, so the two never coincide.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      if (seq_out.busy && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_kind_in   = KIND_REQUEST;
         rsp_byte_in   = seq_out.tx_byte;
         rsp_last_in   = seq_out.last;
         rsp_status_in = STATUS_OK;
         rsp_value_in  = 16'h0000;
      end else if (reply_out.valid) begin
         rsp_valid_in  = 1'b1;
         rsp_kind_in   = KIND_RESULT;
         rsp_byte_in   = 8'h00;
         rsp_last_in   = 1'b0;
         rsp_status_in = reply_out.status;
         rsp_value_in  = reply_out.read_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff     <= 1'b0;
         slave_address_ff <= 8'd1;
         max_value_ff     <= 16'd1999;
      end else begin
         rsp_valid_ff     <= rsp_valid_in;
         slave_address_ff <= slave_address_in;
         max_value_ff     <= max_value_in;
      end
      rsp_kind_ff   <= rsp_kind_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {5'b00000, rsp_value_ff, rsp_status_ff, rsp_byte_ff};

endmodule

[rtl/mrrm_checker.sv]
// Port-level checker for the read register master, bound to the top level.
`include "assert_macros.svh"

module mrrm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic        rsp_tuser,
   input logic        rsp_tlast,
   input logic [31:0] rsp_tdata
);
   import mrrm_pkg::*;

   // A result that is not taken stays unchanged.
   `ASSERT_CLK_RST(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))

   // Only request frame bytes may close a frame.
   `ASSERT_CLK_RST(a_last_is_request, clock, reset, rsp_tvalid && rsp_tlast |-> rsp_tuser == KIND_REQUEST)

   // A read result carries no frame byte and does not close a frame.
   `ASSERT_CLK_RST(a_result_clean, clock, reset, rsp_tvalid && rsp_tuser == KIND_RESULT |-> rsp_tdata[7:0] == 8'h00 && !rsp_tlast)

   // After a start the master is busy sending its frame and takes no further request.
   `ASSERT_CLK_RST(a_start_busy, clock, reset, req_tvalid && req_tready && req_tuser == OP_START |=> !req_tready)

   // The output stage is empty straight after reset.
   `ASSERT_CLK(a_reset_empty, clock, reset |=> !rsp_tvalid)

endmodule

bind modbus_read_register_master mrrm_checker u_mrrm_checker (.*);

[dv/modbus_read_register_master_tb.sv]
// Self-checking testbench for the Modbus RTU read holding register master.
`timescale 1ns / 1ps

module modbus_read_register_master_tb;
   import mrrm_pkg::*;

   // The fourth operation code has no meaning and must be ignored by the block.
   localparam logic [1:0] OP_UNUSED      = 2'd3;
   // Long receiver hold-off, long enough to back the block up into its input.
   localparam int         LONG_HOLD      = 100;
   // Cycles allowed for an ignored request to settle before a register write.
   localparam int         DRAIN_CYCLES   = 12;
   // Cycles without any handshake before the run is declared hung.
   localparam int         WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] reg_word;
      logic [7:0]  rx;
   } bus_request_t;

   typedef struct packed {
      logic        kind;
      logic [7:0]  tx;
      logic        last;
      logic [2:0]  status;
      logic [15:0] value;
   } master_out_t;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [1:0]             req_tuser  = '0;
   logic [23:0]            req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic                   rsp_tuser;
   logic                   rsp_tlast;
   logic [31:0]            rsp_tdata;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [15:0]            csr_data   = '0;

   modbus_read_register_master dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),    // [1:0] operation
      .req_tdata  (req_tdata),    // [15:0] reg_address, [23:16] rx_byte
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),    // [0] kind
      .rsp_tlast  (rsp_tlast),
      .rsp_tdata  (rsp_tdata),    // [7:0] tx_byte, [10:8] status, [26:11] read_value
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Requests waiting to be offered, and the outputs the master should produce.
   bus_request_t pending_requests[$];
   master_out_t  expected_master_out[$];
   int           requests_queued = 0;
   int           requests_taken  = 0;

   // Predictor copy of the configuration and of the reply collector.
   logic [7:0]   cfg_slave      = 8'd1;
   logic [15:0]  cfg_max        = 16'd1999;
   logic         reply_pending  = 1'b0;
   int           reply_count    = 0;
   logic [15:0]  reply_crc      = CRC_INIT;
   logic [7:0]   reply_addr     = 8'h00;
   logic [7:0]   reply_func     = 8'h00;
   logic [7:0]   reply_data_hi  = 8'h00;
   logic [7:0]   reply_data_lo  = 8'h00;

   // What the stimulus believes the configuration to be.
   logic [7:0]   stim_slave = 8'd1;
   logic [15:0]  stim_max   = 16'd1999;

   int           mismatches   = 0;
   int           frame_bytes  = 0;
   int           status_seen[5] = '{default: 0};
   int           hold_requests = 0;
   int           holds_done    = 0;
   int           quiet_cycles  = 0;

   // CRC-16/Modbus, one bit at a time: the feedback is the outgoing LSB
   // combined with the next data bit, LSB first.
   function automatic logic [15:0] modbus_crc_update(input logic [15:0] crc,
                                                     input logic [7:0]  data);
      logic feedback;
      for (int k = 0; k < 8; k++) begin
         feedback = crc[0] ^ data[k];
         crc      = crc >> 1;
         if (feedback) crc = crc ^ CRC_POLY;
      end
      return crc;
   endfunction

   task automatic drop_reply();
      reply_pending = 1'b0;
      reply_count   = 0;
      reply_crc     = CRC_INIT;
      reply_addr    = 8'h00;
      reply_func    = 8'h00;
      reply_data_hi = 8'h00;
      reply_data_lo = 8'h00;
   endtask

   // Works out what one accepted request makes the master emit.
   task automatic predict_master_step(input bus_request_t rq);
      logic [7:0]  frame[8];
      logic [15:0] crc;
      logic [15:0] word;
      master_out_t o;
      o = '0;
      case (rq.op)
         OP_START: begin
            frame[0] = cfg_slave;
            frame[1] = FUNC_READ_HOLDING;
            frame[2] = rq.reg_word[15:8];
            frame[3] = rq.reg_word[7:0];
            frame[4] = READ_COUNT[15:8];
            frame[5] = READ_COUNT[7:0];
            crc = CRC_INIT;
            for (int i = 0; i < 6; i++) crc = modbus_crc_update(crc, frame[i]);
            frame[6] = crc[7:0];
            frame[7] = crc[15:8];
            for (int i = 0; i < 8; i++) begin
               o.kind = KIND_REQUEST;
               o.tx   = frame[i];
               o.last = (i == 7);
               expected_master_out.push_back(o);
            end
            // A new start throws away whatever part of a reply had arrived.
            drop_reply();
            reply_pending = 1'b1;
         end
         OP_RX_BYTE: begin
            if (reply_pending) begin
               case (reply_count)
                  0: reply_addr    = rq.rx;
                  1: reply_func    = rq.rx;
                  3: reply_data_hi = rq.rx;
                  4: reply_data_lo = rq.rx;
                  default: ;
               endcase
               // The byte count and both CRC bytes only feed the CRC.
               reply_crc   = modbus_crc_update(reply_crc, rq.rx);
               reply_count = reply_count + 1;
               if (reply_count == 7) begin
                  o.kind = KIND_RESULT;
                  if (reply_crc != 16'h0000) begin
                     o.status = STATUS_CRC_ERROR;
                  end else if (reply_addr != cfg_slave) begin
                     o.status = STATUS_WRONG_ID;
                  end else if ((reply_func & EXCEPTION_BIT) != 8'h00) begin
                     o.status = STATUS_EXCEPTION;
                  end else begin
                     o.status = STATUS_OK;
                     word     = {reply_data_hi, reply_data_lo};
                     o.value  = (word > cfg_max) ? cfg_max : word;
                  end
                  expected_master_out.push_back(o);
                  drop_reply();
               end
            end
         end
         OP_TIMEOUT: begin
            if (reply_pending) begin
               o.kind   = KIND_RESULT;
               o.status = STATUS_TIMEOUT;
               expected_master_out.push_back(o);
               drop_reply();
            end
         end
         default: ;
      endcase
   endtask

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= 40) $display("[%0t] mismatch: %s", $time, what);
   endtask

   // ---------------------------------------------------------------------
   // Sender: offers queued requests in bursts of random length separated by
   // random gaps; a gap of zero gives stretches of back-to-back requests.
   // ---------------------------------------------------------------------
   bus_request_t drive_item;
   int           burst_left = 0;
   int           gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left > 0 || pending_requests.size() == 0) begin
            if (gap_left > 0) gap_left--;
            req_tvalid <= 1'b0;
         end else begin
            drive_item = pending_requests.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= drive_item.op;
            req_tdata  <= {drive_item.rx, drive_item.reg_word};
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 24);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: switches between stall patterns after runs of random length, so
   // stalls land on every byte of a frame. A hold-off request from the
   // stimulus makes it refuse results for a hold-off whose length is set by LONG_HOLD.
   // ---------------------------------------------------------------------
   int         stall_left   = 0;
   int         pattern_left = 0;
   int         pattern_mode = 0;
   logic [7:0] pattern_phase = 8'h00;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (holds_done != hold_requests) begin
         holds_done++;
         stall_left = LONG_HOLD - 1;
         rsp_tready <= 1'b0;
      end else begin
         if (pattern_left == 0) begin
            pattern_mode = $urandom_range(0, 3);
            pattern_left = $urandom_range(8, 64);
         end else begin
            pattern_left--;
         end
         pattern_phase = pattern_phase + 8'd1;
         case (pattern_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= pattern_phase[0];
            2:       rsp_tready <= ($urandom_range(0, 99) < 45);
            default: rsp_tready <= (pattern_phase[1:0] != 2'b11);
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: checks each accepted result against the oldest expectation,
   // then tracks register writes and predicts from each accepted request.
   // A result is never accepted at the edge that takes its own request.
   // ---------------------------------------------------------------------
   master_out_t  want;
   bus_request_t seen_request;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_master_out.size() == 0) begin
               report_mismatch($sformatf("result with nothing outstanding: kind %0b data %08h",
                                         rsp_tuser, rsp_tdata));
            end else begin
               want = expected_master_out.pop_front();
               if (rsp_tuser !== want.kind)
                  report_mismatch($sformatf("kind got %0b want %0b", rsp_tuser, want.kind));
               if (rsp_tdata[7:0] !== want.tx)
                  report_mismatch($sformatf("tx_byte got %02h want %02h",
                                            rsp_tdata[7:0], want.tx));
               if (rsp_tlast !== want.last)
                  report_mismatch($sformatf("last got %0b want %0b", rsp_tlast, want.last));
               if (rsp_tdata[10:8] !== want.status)
                  report_mismatch($sformatf("status got %0d want %0d",
                                            rsp_tdata[10:8], want.status));
               if (rsp_tdata[26:11] !== want.value)
                  report_mismatch($sformatf("read_value got %04h want %04h",
                                            rsp_tdata[26:11], want.value));
               if (rsp_tdata[31:27] !== 5'd0)
                  report_mismatch($sformatf("padding bits got %02h", rsp_tdata[31:27]));
               if (want.kind == KIND_RESULT) status_seen[want.status]++;
               else frame_bytes++;
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SLAVE_ADDRESS: cfg_slave = csr_data[7:0];
               CSR_MAX_VALUE:     cfg_max   = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            requests_taken++;
            seen_request.op       = req_tuser;
            seen_request.reg_word = req_tdata[15:0];
            seen_request.rx       = req_tdata[23:16];
            predict_master_step(seen_request);
         end
      end
   end

   // Watchdog: any handshake on any channel counts as progress.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no handshake for %0d cycles, %0d outputs outstanding",
                     $time, quiet_cycles, expected_master_out.size());
            $display("FAILURE");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic queue_request(input logic [1:0] op, input logic [15:0] reg_word,
                                input logic [7:0] rx);
      bus_request_t rq;
      rq.op       = op;
      rq.reg_word = reg_word;
      rq.rx       = rx;
      pending_requests.push_back(rq);
      requests_queued++;
   endtask

   // Queues a seven-byte reply with its CRC; corrupt_at selects a byte that
   // gets one bit flipped after the CRC is worked out, or -1 for none.
   task automatic send_reply(input logic [7:0] addr, input logic [7:0] func,
                             input logic [7:0] count_field, input logic [15:0] word,
                             input int corrupt_at);
      logic [7:0]  fr[7];
      logic [15:0] crc;
      fr[0] = addr;
      fr[1] = func;
      fr[2] = count_field;
      fr[3] = word[15:8];
      fr[4] = word[7:0];
      crc = CRC_INIT;
      for (int i = 0; i < 5; i++) crc = modbus_crc_update(crc, fr[i]);
      fr[5] = crc[7:0];
      fr[6] = crc[15:8];
      if (corrupt_at >= 0) fr[corrupt_at] = fr[corrupt_at] ^ (8'h01 << $urandom_range(0, 7));
      for (int i = 0; i < 7; i++) queue_request(OP_RX_BYTE, 16'($urandom), fr[i]);
   endtask

   // Data words cluster around the saturation limit and the range ends.
   function automatic logic [15:0] pick_data();
      case ($urandom_range(0, 5))
         0:       return stim_max;
         1:       return stim_max + 16'd1;
         2:       return stim_max - 16'd1;
         3:       return 16'h0000;
         4:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [15:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(input logic [7:0] slave, input logic [15:0] max_word);
      write_reg(CSR_SLAVE_ADDRESS, {8'h00, slave});
      write_reg(CSR_MAX_VALUE, max_word);
      stim_slave = slave;
      stim_max   = max_word;
   endtask

   // Holds the test sequence back until every request is taken and every result
   // has arrived, then lets an ignored last request settle.
   task automatic wait_for_idle();
      do @(posedge clock);
      while (requests_taken != requests_queued || expected_master_out.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Mostly complete read transactions with random content; the remainder
   // are abandoned replies, timeouts, restarted reads and plain noise.
   task automatic run_random_phase(input int target);
      int         made;
      int         r;
      int         nbytes;
      int         corrupt_at;
      logic [7:0] addr;
      logic [7:0] func;
      logic [7:0] count_field;
      made = 0;
      while (made < target) begin
         r = $urandom_range(0, 99);
         if (r >= 88) begin
            repeat ($urandom_range(1, 3))
               queue_request(2'($urandom_range(0, 3)), 16'($urandom), 8'($urandom));
         end else begin
            queue_request(OP_START, 16'($urandom), 8'($urandom));
            made++;
            if (r < 66) begin
               addr        = stim_slave;
               func        = FUNC_READ_HOLDING;
               count_field = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h02;
               corrupt_at  = -1;
               // Any function code without the exception bit still reads as good.
               if ($urandom_range(0, 7) == 0) func = 8'($urandom) & ~EXCEPTION_BIT;
               if (r >= 40 && r < 50) corrupt_at = $urandom_range(0, 6);
               else if (r >= 50 && r < 58) addr = stim_slave ^ 8'($urandom_range(1, 255));
               else if (r >= 58) func = 8'($urandom) | EXCEPTION_BIT;
               send_reply(addr, func, count_field, pick_data(), corrupt_at);
               made += 7;
            end else begin
               nbytes = (r >= 74 && r < 80) ? 0 : $urandom_range(1, 6);
               repeat (nbytes) queue_request(OP_RX_BYTE, 16'($urandom), 8'($urandom));
               made += nbytes;
               // Without the timeout the next start flushes the partial reply.
               if (r < 80) begin
                  queue_request(OP_TIMEOUT, 16'($urandom), 8'($urandom));
                  made++;
               end
            end
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part, with the reset configuration. Requests that arrive
      // while no read is pending, and the unused operation, must vanish.
      queue_request(OP_RX_BYTE, 16'h0000, 8'hFF);
      queue_request(OP_TIMEOUT, 16'hFFFF, 8'h00);
      queue_request(OP_UNUSED, 16'hFFFF, 8'hFF);
      // Good reply whose data word is above the limit; the byte count is
      // deliberately wrong, as the master never looks at it.
      queue_request(OP_START, 16'h0000, 8'h00);
      send_reply(stim_slave, FUNC_READ_HOLDING, 8'h00, 16'hFFFF, -1);
      // Read abandoned by a timeout.
      queue_request(OP_START, 16'hFFFF, 8'hFF);
      queue_request(OP_TIMEOUT, 16'h0000, 8'h00);
      // Partial reply flushed by a fresh start, which then gets an exception.
      queue_request(OP_START, 16'h1234, 8'h00);
      repeat (3) queue_request(OP_RX_BYTE, 16'h0000, 8'($urandom));
      queue_request(OP_START, 16'hA5C3, 8'h00);
      send_reply(stim_slave, FUNC_READ_HOLDING | EXCEPTION_BIT, 8'h01, 16'h0002, -1);
      wait_for_idle();

      // Highest address and no effective saturation. The receiver holds off
      // for a long stretch while the sender keeps offering, so the output
      // stage fills and the block has to stall its request input.
      configure(8'd247, 16'hFFFF);
      run_random_phase(42);
      hold_requests++;
      wait_for_idle();

      // Lowest address, and every good read saturates to zero.
      configure(8'd1, 16'h0000);
      run_random_phase(42);
      wait_for_idle();

      configure(8'($urandom_range(2, 246)), 16'($urandom));
      run_random_phase(42);
      wait_for_idle();

      configure(8'($urandom_range(1, 247)), 16'd1999);
      run_random_phase(42);
      wait_for_idle();

      $display("Run covered %0d requests and %0d request frame bytes across five settings.",
               requests_taken, frame_bytes);
      $display("Reads ended ok %0d, timeout %0d, bad CRC %0d, wrong slave %0d, exception %0d.",
               status_seen[STATUS_OK], status_seen[STATUS_TIMEOUT],
               status_seen[STATUS_CRC_ERROR], status_seen[STATUS_WRONG_ID],
               status_seen[STATUS_EXCEPTION]);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
